/* sv/crb_pkg.sv */
package crb_pkg;

  localparam int WORD_BITS = 32;
  localparam int TOL_BITS  = 31;
  localparam int ITER_BITS = $clog2(WORD_BITS + 1);
  localparam int PC_BITS   = 3;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(655);

  // Result status codes
  localparam logic [1:0] ST_WIDTH = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] left_end;
    logic signed [WORD_BITS-1:0] right_end;
  } crb_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] root;
    logic [1:0]                  status;
  } crb_out_t;

  // Jump conditions of the microprogram
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD,
    COND_STOP,
    COND_NONZERO,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    cond_e              cond;
    logic [PC_BITS-1:0] target;
    logic               take;
    logic               load_mid;
    logic               update;
    logic               set_zero;
    logic               set_bad;
    logic               emit;
  } ctl_t;

  typedef struct packed {
    logic bad;
    logic stop;
    logic nonzero;
    logic out_busy;
  } flags_t;

  // Program steps
  localparam logic [PC_BITS-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_BITS-1:0] STEP_CHECK = 3'd1;
  localparam logic [PC_BITS-1:0] STEP_TEST  = 3'd2;
  localparam logic [PC_BITS-1:0] STEP_MID   = 3'd3;
  localparam logic [PC_BITS-1:0] STEP_UPD   = 3'd4;
  localparam logic [PC_BITS-1:0] STEP_ZERO  = 3'd5;
  localparam logic [PC_BITS-1:0] STEP_BAD   = 3'd6;
  localparam logic [PC_BITS-1:0] STEP_EMIT  = 3'd7;

  // Control store: one control word per step; falling through the last
  // step wraps to the idle step.
  function automatic ctl_t crb_ucode(logic [PC_BITS-1:0] pc);
    ctl_t w;
    w = '{cond: COND_NEXT, target: STEP_IDLE, default: 1'b0};
    unique case (pc)
      STEP_IDLE: begin
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
        w.take   = 1'b1;
      end
      STEP_CHECK: begin
        w.cond   = COND_BAD;
        w.target = STEP_BAD;
      end
      STEP_TEST: begin
        w.cond   = COND_STOP;
        w.target = STEP_EMIT;
      end
      STEP_MID: begin
        w.load_mid = 1'b1;
      end
      STEP_UPD: begin
        w.cond   = COND_NONZERO;
        w.target = STEP_TEST;
        w.update = 1'b1;
      end
      STEP_ZERO: begin
        w.cond     = COND_ALWAYS;
        w.target   = STEP_EMIT;
        w.set_zero = 1'b1;
      end
      STEP_BAD: begin
        w.set_bad = 1'b1;
      end
      STEP_EMIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
        w.emit   = 1'b1;
      end
      default: begin
        w.cond = COND_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/crb_seq.sv */
module crb_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  crb_pkg::flags_t flags_i,
  output crb_pkg::ctl_t ctl_o
);
  import crb_pkg::*;

  logic [PC_BITS-1:0] pc_q, pc_d;
  ctl_t               ctl;
  logic               jump;

  assign ctl   = crb_ucode(pc_q);
  assign ctl_o = ctl;

  always_comb begin
    unique case (ctl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !in_valid_i;
      COND_BAD:      jump = flags_i.bad;
      COND_STOP:     jump = flags_i.stop;
      COND_NONZERO:  jump = flags_i.nonzero;
      COND_OUT_BUSY: jump = flags_i.out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? ctl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* sv/crb_dp.sv */
module crb_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  crb_pkg::ctl_t                  ctl_i,
  input  crb_pkg::crb_in_t               in_word_i,
  input  logic [crb_pkg::TOL_BITS-1:0]   tol_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output crb_pkg::crb_out_t              out_word_o,
  output crb_pkg::flags_t                flags_o
);
  import crb_pkg::*;

  // -1.0 is the only real root of the cubic, and f changes sign there
  localparam logic signed [WORD_BITS-1:0] NegOne = -(WORD_BITS'(1) << FRAC_BITS);

  logic signed [WORD_BITS-1:0] a_q, b_q, c_q;
  logic [ITER_BITS-1:0]        iter_q;
  logic [1:0]                  status_q;
  logic                        out_valid_q;
  crb_out_t                    out_q;

  logic signed [WORD_BITS:0]   sum, width, tol_ext;
  logic a_pos, a_zero, b_pos, b_zero, c_pos, go, out_busy;

  assign a_pos  = a_q > NegOne;
  assign a_zero = a_q == NegOne;
  assign b_pos  = b_q > NegOne;
  assign b_zero = b_q == NegOne;
  assign c_pos  = c_q > NegOne;

  assign sum     = $signed({a_q[WORD_BITS-1], a_q}) + $signed({b_q[WORD_BITS-1], b_q});
  assign width   = $signed({b_q[WORD_BITS-1], b_q}) - $signed({a_q[WORD_BITS-1], a_q});
  assign tol_ext = $signed({{(WORD_BITS + 1 - TOL_BITS){1'b0}}, tol_i});
  assign go      = (width >= tol_ext) && (iter_q < ITER_BITS'(WORD_BITS));

  assign out_busy = out_valid_q && out_stall_i;

  assign flags_o.bad      = a_zero || b_zero || (a_pos == b_pos);
  assign flags_o.stop     = !go;
  assign flags_o.nonzero  = c_q != NegOne;
  assign flags_o.out_busy = out_busy;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      a_q      <= in_word_i.left_end;
      b_q      <= in_word_i.right_end;
      c_q      <= in_word_i.left_end;
      iter_q   <= '0;
      status_q <= ST_WIDTH;
    end
    if (ctl_i.load_mid) begin
      c_q    <= sum[WORD_BITS:1];
      iter_q <= iter_q + 1'b1;
    end
    // replace the end whose sign matches the midpoint
    if (ctl_i.update) begin
      if (c_pos != a_pos) begin
        b_q <= c_q;
      end else begin
        a_q <= c_q;
      end
    end
    if (ctl_i.set_zero) begin
      status_q <= ST_ZERO;
    end
    if (ctl_i.set_bad) begin
      status_q <= ST_BAD;
      c_q      <= '0;
    end
    if (ctl_i.emit && !out_busy) begin
      out_q.root   <= c_q;
      out_q.status <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

/* sv/cubic_root_bisection.sv */
// Bisection root finder for f(x) = x^3 - x^2 + 2 on signed Q16.16 words.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one word carries an
// interval (left_end, right_end). A word is taken at a clock edge with
// in_valid_i high and in_stall_o low. Output channel (out_valid_o /
// out_stall_i / out_word_o): one word per input with the root and status
// (0 stopped by width or halving limit, 1 exact zero at -1.0, 2 ends not bracketing).
// cfg_we_i writes cfg_wdata_i into the tolerance register; write it only
// while the block is idle.
//
// A small microprogram (eight steps, one control word each) sequences a
// datapath holding the interval ends and the midpoint. Each halving takes
// three steps (test width, form midpoint, update an end), with at most 32
// halvings per word; a bad bracket goes through the bad step straight to
// the emit step, and a midpoint at exactly -1.0 ends the halvings early.
// One item is in work at a time; the output register holds a finished word
// while the next item is accepted and processed, and the sequencer waits
// at its emit step only if that register is still stalled.
// Reset clears the sequencer, drops out_valid_o and sets tolerance 655 (~0.01).
module cubic_root_bisection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  crb_pkg::crb_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output crb_pkg::crb_out_t             out_word_o,
  input  logic                          cfg_we_i,
  input  logic [crb_pkg::TOL_BITS-1:0]  cfg_wdata_i
);
  import crb_pkg::*;

  localparam logic signed [WORD_BITS-1:0] NegOne = -(WORD_BITS'(1) << FRAC_BITS);

  logic [TOL_BITS-1:0] tol_q;
  ctl_t                ctl;
  flags_t              flags;

  // Tolerance register: hold until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Step counter and control store
  crb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctl_o      (ctl)
  );

  // Interval registers, midpoint, sign tests and output register
  crb_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_word_i   (in_word_i),
    .tol_i       (tol_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .flags_o     (flags)
  );

  // Accept only at the idle step
  assign in_stall_o = !ctl.take;

  // A bad bracket always reports a zero root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_BAD) |-> out_word_o.root == '0)
    else $error("bad bracket with nonzero root");

  // An exact zero can only be the point -1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_ZERO) |-> out_word_o.root == NegOne)
    else $error("exact zero reported away from -1.0");

  // After taking a word the block is busy on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in work");

  // A new result only enters a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit && !flags.out_busy |=> out_valid_o)
    else $error("emitted result lost");

endmodule
